### sv/vuh_pkg.sv
package vuh_pkg;

    // key store geometry
    localparam int unsigned KEY_DEPTH = 41;
    localparam int unsigned KEY_AW    = $clog2(KEY_DEPTH);

    // bytes of h3 appended after h2
    localparam int unsigned TAIL_BYTES = 2;
    localparam int unsigned TAIL_USED  = (TAIL_BYTES > 8) ? 8 : TAIL_BYTES;
    localparam logic [3:0]  TAIL_OB    = 4'(TAIL_USED);
    localparam logic [2:0]  TAIL_STEP  = (TAIL_USED > 0) ? 3'd1 : 3'd0;

    // item kinds
    localparam logic [1:0] KIND_SEED = 2'd0;
    localparam logic [1:0] KIND_MSG  = 2'd1;
    localparam logic [1:0] KIND_MASK = 2'd2;

    // reduction polynomials, low part
    localparam logic [10:0] POLY_64  = 11'h01B;
    localparam logic [10:0] POLY_LOW = 11'h087;
    localparam logic [10:0] POLY_256 = 11'h425;

    // request to the shared field multiplier
    typedef struct packed {
        logic        start;
        logic [1:0]  nwm1;
        logic [10:0] poly;
    } mul_req_t;

    // low n bytes set, n above 8 taken as 8
    function automatic logic [63:0] bytes_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (n > 4'(i))
                m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // words 0..nwm1 set
    function automatic logic [255:0] word_mask(input logic [1:0] nwm1);
        logic [255:0] m;
        m = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (nwm1 >= 2'(i))
                m[i*64 +: 64] = '1;
        end
        return m;
    endfunction

    // words per field element minus one
    function automatic logic [1:0] level_nwm1(input logic [1:0] level);
        logic [1:0] r;
        case (level)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

### sv/vuh_ram.sv
module vuh_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 41
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/vuh_gf_mul.sv
module vuh_gf_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  vuh_pkg::mul_req_t req,
    input  logic [255:0]      a,
    input  logic [255:0]      b,
    output logic              done,
    output logic [255:0]      product
);

    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   bit_reg;
    logic [1:0]   nwm1_reg;
    logic [10:0]  poly_reg;
    logic [255:0] a_reg;
    logic [255:0] b_reg;
    logic [255:0] acc_reg;
    logic [255:0] acc_next;
    logic [7:0]   top;

    // one bit of b per cycle, msb first: shift, reduce, add a
    always_comb
    begin
        top      = {nwm1_reg, 6'h3F};
        acc_next = (acc_reg << 1) & vuh_pkg::word_mask(nwm1_reg);
        if (acc_reg[top])
            acc_next[10:0] = acc_next[10:0] ^ poly_reg;
        if (b_reg[bit_reg])
            acc_next = acc_next ^ a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
            nwm1_reg <= '0;
            poly_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                bit_reg  <= {req.nwm1, 6'h3F};
                nwm1_reg <= req.nwm1;
                poly_reg <= req.poly;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg  <= acc_next;
                done_reg <= (bit_reg == 8'd0);
                if (bit_reg == 8'd0)
                    busy_reg <= 1'b0;
                else
                    bit_reg <= bit_reg - 8'd1;
            end
            else
                done_reg <= 1'b0;
        end
    end

    // operands, trimmed to the field width
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= a & vuh_pkg::word_mask(req.nwm1);
            b_reg <= b & vuh_pkg::word_mask(req.nwm1);
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### sv/vole_universal_hash_core.sv
// channel | direction | handshake           | payload
// in      | to core   | in_valid, in_stall  | kind, seed_index, data_word, byte_count, last
// out     | from core | out_valid, out_stall| out_word, out_bytes, out_last
// cfg     | to core   | cfg_valid, cfg_ready| security_level
//
// seed, mask and non-closing message items leave the sequencer idle.
// a chunk-closing message item loads key words and runs one wide and nw narrow multiplies
// on the bit-serial field multiplier (nw = lambda/64); a last message
// item adds four key loads and four multiplies.
// reset clears all hash state and selects lambda 128; key store is not cleared.
// the input stalls while a chunk is in work or an output item is held by out_stall.
module vole_universal_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [5:0]  seed_index,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_word,
    output logic [3:0]  out_bytes,
    output logic        out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  security_level
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CAP,
        ST_MUL_GO,
        ST_MUL_WAIT
    } state_t;

    typedef enum logic [2:0] {
        PH_WIDE,
        PH_NARROW,
        PH_FIN0,
        PH_FIN1,
        PH_FIN2,
        PH_FIN3
    } phase_t;

    state_t       state_reg;
    phase_t       phase_reg;
    logic [1:0]   level_reg;
    logic         fin_reg;
    logic [2:0]   cnt_reg;
    logic [2:0]   limit_reg;
    logic [5:0]   base_reg;
    logic [1:0]   k_reg;
    logic [255:0] key_reg;
    logic [63:0]  t_reg;
    logic [255:0] hw_reg;
    logic [63:0]  hn_reg;
    logic [255:0] chunk_reg;
    logic [1:0]   wpos_reg;
    logic [255:0] hash_reg;
    logic [63:0]  tail_reg;
    logic [255:0] tmp_reg;
    logic [2:0]   mpos_reg;
    logic         out_valid_reg;
    logic [63:0]  out_word_reg;
    logic [3:0]   out_bytes_reg;
    logic         out_last_reg;

    logic         accept;
    logic [1:0]   nwm1;
    logic [2:0]   nw;
    logic [63:0]  data_m;
    logic         ram_we;
    logic [vuh_pkg::KEY_AW-1:0] ram_raddr;
    logic [63:0]  ram_rdata;
    vuh_pkg::mul_req_t mul_req;
    logic [255:0] mul_a;
    logic [255:0] mul_b;
    logic         mul_done;
    logic [255:0] mul_p;
    logic [2:0]   final_pos;
    logic [2:0]   mp;
    logic         mp_main;
    logic [63:0]  hash_word;
    logic [3:0]   ob;
    logic [255:0] chunk_new;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign nwm1   = vuh_pkg::level_nwm1(level_reg);
    assign nw     = {1'b0, nwm1} + 3'd1;
    assign data_m = data_word & vuh_pkg::bytes_mask(byte_count);

    // key store
    assign ram_we    = accept && (kind == vuh_pkg::KIND_SEED)
                       && (seed_index < 6'(vuh_pkg::KEY_DEPTH));
    assign ram_raddr = vuh_pkg::KEY_AW'(base_reg + {3'd0, cnt_reg});

    vuh_ram #(
        .WIDTH (64),
        .DEPTH (vuh_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vuh_pkg::KEY_AW'(seed_index)),
        .wdata (data_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // multiplier operands by phase
    always_comb
    begin
        mul_req.start = (state_reg == ST_MUL_GO);
        mul_req.nwm1  = nwm1;
        mul_req.poly  = (level_reg >= 2'd2) ? vuh_pkg::POLY_256 : vuh_pkg::POLY_LOW;
        mul_a         = key_reg;
        mul_b         = hw_reg;
        case (phase_reg) inside
            PH_NARROW:
            begin
                mul_req.nwm1 = 2'd0;
                mul_req.poly = vuh_pkg::POLY_64;
                mul_a        = {192'd0, t_reg};
                mul_b        = {192'd0, hn_reg};
            end
            PH_FIN1, PH_FIN3:
                mul_b = {192'd0, hn_reg};
            default:
                mul_b = hw_reg;
        endcase
    end

    vuh_gf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // mask word selection
    always_comb
    begin
        final_pos = {1'b0, nwm1} + vuh_pkg::TAIL_STEP;
        mp        = (mpos_reg > final_pos) ? final_pos : mpos_reg;
        mp_main   = (mp < nw);
        hash_word = mp_main ? hash_reg[mp[1:0]*64 +: 64] : tail_reg;
        ob        = mp_main ? 4'd8 : vuh_pkg::TAIL_OB;
        chunk_new = chunk_reg;
        chunk_new[wpos_reg*64 +: 64] = data_m;
    end

    // sequencer and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WIDE;
            level_reg     <= 2'd0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            key_reg       <= '0;
            t_reg         <= '0;
            hw_reg        <= '0;
            hn_reg        <= '0;
            chunk_reg     <= '0;
            wpos_reg      <= '0;
            hash_reg      <= '0;
            tail_reg      <= '0;
            tmp_reg       <= '0;
            mpos_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_bytes_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !(accept && kind == vuh_pkg::KIND_MASK))
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                level_reg <= security_level;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && kind == vuh_pkg::KIND_MSG)
                    begin
                        if (last || wpos_reg >= nwm1)
                        begin
                            chunk_reg <= chunk_new;
                            fin_reg   <= last;
                            phase_reg <= PH_WIDE;
                            cnt_reg   <= '0;
                            limit_reg <= nw + 3'd1;
                            base_reg  <= {1'b0, nw, 2'b00};
                            key_reg   <= '0;
                            state_reg <= ST_RD;
                        end
                        else
                        begin
                            chunk_reg <= chunk_new;
                            wpos_reg  <= wpos_reg + 2'd1;
                        end
                    end
                    else if (accept && kind == vuh_pkg::KIND_MASK)
                    begin
                        out_valid_reg <= 1'b1;
                        out_word_reg  <= (data_m ^ hash_word) & vuh_pkg::bytes_mask(ob);
                        out_bytes_reg <= ob;
                        out_last_reg  <= (mp == final_pos);
                        if (mp == final_pos || last)
                        begin
                            hash_reg  <= '0;
                            tail_reg  <= '0;
                            mpos_reg  <= '0;
                            hw_reg    <= '0;
                            hn_reg    <= '0;
                            chunk_reg <= '0;
                            wpos_reg  <= '0;
                        end
                        else
                            mpos_reg <= mp + 3'd1;
                    end
                end

                ST_RD:
                    state_reg <= ST_CAP;

                ST_CAP:
                begin
                    if (cnt_reg < nw)
                        key_reg[cnt_reg[1:0]*64 +: 64] <= ram_rdata;
                    else
                        t_reg <= ram_rdata;
                    if (cnt_reg + 3'd1 == limit_reg)
                        state_reg <= ST_MUL_GO;
                    else
                    begin
                        cnt_reg   <= cnt_reg + 3'd1;
                        state_reg <= ST_RD;
                    end
                end

                ST_MUL_GO:
                    state_reg <= ST_MUL_WAIT;

                ST_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        // prepare the next key load of the final products
                        cnt_reg   <= '0;
                        limit_reg <= nw;
                        case (phase_reg)
                            PH_WIDE:
                            begin
                                hw_reg    <= mul_p ^ (chunk_reg & vuh_pkg::word_mask(nwm1));
                                phase_reg <= PH_NARROW;
                                k_reg     <= '0;
                                state_reg <= ST_MUL_GO;
                            end
                            PH_NARROW:
                            begin
                                hn_reg <= mul_p[63:0] ^ chunk_reg[k_reg*64 +: 64];
                                if (k_reg == nwm1)
                                begin
                                    chunk_reg <= '0;
                                    wpos_reg  <= '0;
                                    if (fin_reg)
                                    begin
                                        phase_reg <= PH_FIN0;
                                        base_reg  <= '0;
                                        key_reg   <= '0;
                                        state_reg <= ST_RD;
                                    end
                                    else
                                        state_reg <= ST_IDLE;
                                end
                                else
                                begin
                                    k_reg     <= k_reg + 2'd1;
                                    state_reg <= ST_MUL_GO;
                                end
                            end
                            PH_FIN0:
                            begin
                                tmp_reg   <= mul_p;
                                phase_reg <= PH_FIN1;
                                base_reg  <= {3'd0, nw};
                                key_reg   <= '0;
                                state_reg <= ST_RD;
                            end
                            PH_FIN1:
                            begin
                                hash_reg  <= tmp_reg ^ mul_p;
                                phase_reg <= PH_FIN2;
                                base_reg  <= {2'd0, nw, 1'b0};
                                key_reg   <= '0;
                                state_reg <= ST_RD;
                            end
                            PH_FIN2:
                            begin
                                tmp_reg   <= mul_p;
                                phase_reg <= PH_FIN3;
                                base_reg  <= {3'd0, nw} + {2'd0, nw, 1'b0};
                                key_reg   <= '0;
                                state_reg <= ST_RD;
                            end
                            default:
                            begin
                                tail_reg  <= (tmp_reg[63:0] ^ mul_p[63:0])
                                             & vuh_pkg::bytes_mask(vuh_pkg::TAIL_OB);
                                mpos_reg  <= '0;
                                hw_reg    <= '0;
                                hn_reg    <= '0;
                                chunk_reg <= '0;
                                wpos_reg  <= '0;
                                key_reg   <= '0;
                                phase_reg <= PH_WIDE;
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_bytes = out_bytes_reg;
    assign out_last  = out_last_reg;

endmodule
